>>> rtl/core/b64d_pkg.sv
// shared types, codes and the alphabet lookup for the base64 stream decoder
// no dependencies
package b64d_pkg;

    // input selector codes (carried in tuser)
    localparam logic OP_DATA   = 1'b0;
    localparam logic OP_FINISH = 1'b1;

    // result kind codes (carried in tuser)
    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // status codes
    localparam logic ST_OK  = 1'b0;
    localparam logic ST_ERR = 1'b1;

    // decoded character classes beyond the 64 alphabet values
    localparam logic [6:0] VAL_PAD = 7'd64;
    localparam logic [6:0] VAL_BAD = 7'd65;

    // alphabet characters
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5a;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7a;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_PLUS    = 8'h2b;
    localparam logic [7:0] CH_SLASH   = 8'h2f;
    localparam logic [7:0] CH_EQUAL   = 8'h3d;

    localparam logic [7:0] OFS_LOWER = 8'd26;
    localparam logic [7:0] OFS_DIGIT = 8'd52;
    localparam logic [6:0] VAL_PLUS  = 7'd62;
    localparam logic [6:0] VAL_SLASH = 7'd63;

    // depth of the job queue between front and back
    localparam int QUEUE_DEPTH_DEF = 2;

    // one queued job: one to three results
    typedef struct packed {
        logic            kind;
        logic            status;
        logic [1:0]      count;   // results in this job, 1..3
        logic [2:0][7:0] bytes;   // bytes[0] goes out first
    } t_job;

    function automatic logic [6:0] char_value(input logic [7:0] c);
        logic [7:0] v;
        v = 8'd0;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            v = c - CH_UPPER_A;
            return v[6:0];
        end
        if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            v = c - CH_LOWER_A + OFS_LOWER;
            return v[6:0];
        end
        if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
            v = c - CH_DIGIT_0 + OFS_DIGIT;
            return v[6:0];
        end
        if (c == CH_PLUS)  return VAL_PLUS;
        if (c == CH_SLASH) return VAL_SLASH;
        if (c == CH_EQUAL) return VAL_PAD;
        return VAL_BAD;
    endfunction

endpackage

>>> rtl/core/b64d_front.sv
// front part: accepts characters, tracks quartet state and builds result jobs
// depends on b64d_pkg
module b64d_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic             i_op,
    input  logic [7:0]       i_char,
    input  logic             i_chunk_end,
    output logic             o_push,
    output b64d_pkg::t_job   o_job
);

    logic [5:0] r_held0, r_held1, r_held2;
    logic [5:0] n_held0, n_held1, n_held2;
    logic [1:0] r_count, n_count;
    logic       r_third_pad, n_third_pad;
    logic       r_done, n_done;
    logic       r_err, n_err;

    logic [6:0] val;
    logic       is_pad;
    logic       pad4;
    logic [5:0] d;
    logic       want;       // a result is produced
    logic       rep;        // the result is a status report
    logic       rep_status;

    always_comb begin
        val         = b64d_pkg::char_value(i_char);
        is_pad      = (val == b64d_pkg::VAL_PAD);
        pad4        = is_pad;
        d           = pad4 ? 6'd0 : val[5:0];
        n_held0     = r_held0;
        n_held1     = r_held1;
        n_held2     = r_held2;
        n_count     = r_count;
        n_third_pad = r_third_pad;
        n_done      = r_done;
        want        = 1'b0;
        rep         = 1'b0;
        rep_status  = b64d_pkg::ST_ERR;

        if (r_err) begin
            want = 1'b1;
            rep  = 1'b1;
        end else if (i_op == b64d_pkg::OP_FINISH) begin
            want = 1'b1;
            rep  = 1'b1;
            if (r_count == 2'd0) begin
                n_done     = 1'b1;
                rep_status = b64d_pkg::ST_OK;
            end
        end else if (r_done || val == b64d_pkg::VAL_BAD) begin
            want = 1'b1;
            rep  = 1'b1;
        end else if (r_count < 2'd2) begin
            if (is_pad) begin
                want = 1'b1;
                rep  = 1'b1;
            end else begin
                if (r_count[0]) n_held1 = val[5:0];
                else            n_held0 = val[5:0];
                n_count = r_count + 2'd1;
            end
        end else if (r_count == 2'd2) begin
            n_third_pad = is_pad;
            n_held2     = is_pad ? 6'd0 : val[5:0];
            n_count     = 2'd3;
        end else begin
            // fourth character closes the quartet
            want = 1'b1;
            if (r_third_pad && !pad4) begin
                rep = 1'b1;
            end else begin
                if (r_third_pad || pad4) begin
                    n_done = 1'b1;
                    if (!i_chunk_end) rep = 1'b1;
                end
                if (!rep) begin
                    n_count     = 2'd0;
                    n_third_pad = 1'b0;
                end
            end
        end
        n_err = r_err | (want & rep & (rep_status == b64d_pkg::ST_ERR));
    end

    always_comb begin
        o_push = i_accept & want;
        if (rep) begin
            o_job.kind   = b64d_pkg::KIND_STATUS;
            o_job.status = rep_status;
            o_job.count  = 2'd1;
            o_job.bytes  = '0;
        end else begin
            o_job.kind     = b64d_pkg::KIND_DATA;
            o_job.status   = b64d_pkg::ST_OK;
            o_job.count    = r_third_pad ? 2'd1 : (pad4 ? 2'd2 : 2'd3);
            o_job.bytes[0] = {r_held0, r_held1[5:4]};
            o_job.bytes[1] = {r_held1[3:0], r_held2[5:2]};
            o_job.bytes[2] = {r_held2[1:0], d};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held0     <= '0;
            r_held1     <= '0;
            r_held2     <= '0;
            r_count     <= '0;
            r_third_pad <= 1'b0;
            r_done      <= 1'b0;
            r_err       <= 1'b0;
        end else if (i_accept) begin
            r_held0     <= n_held0;
            r_held1     <= n_held1;
            r_held2     <= n_held2;
            r_count     <= n_count;
            r_third_pad <= n_third_pad;
            r_done      <= n_done;
            r_err       <= n_err;
        end
    end

endmodule

>>> rtl/core/b64d_queue.sv
// short job queue between the front and the back part
// depends on b64d_pkg
module b64d_queue #(
    parameter int DEPTH = b64d_pkg::QUEUE_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  b64d_pkg::t_job i_job,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output b64d_pkg::t_job o_job
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    b64d_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_fill;

    assign o_full  = (r_fill == CW'(DEPTH));
    assign o_empty = (r_fill == '0);
    assign o_job   = r_mem[r_rd_ptr];

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) r_wr_ptr <= ptr_inc(r_wr_ptr);
            if (i_pop)  r_rd_ptr <= ptr_inc(r_rd_ptr);
            if (i_push && !i_pop)      r_fill <= r_fill + CW'(1);
            else if (!i_push && i_pop) r_fill <= r_fill - CW'(1);
        end
    end

endmodule

>>> rtl/core/b64d_back.sv
// back part: takes jobs off the queue and sends their results one per cycle while the result side is ready
// depends on b64d_pkg
module b64d_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  b64d_pkg::t_job i_job,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic           o_kind,
    output logic [7:0]     o_byte,
    output logic           o_status,
    output logic           o_last
);

    b64d_pkg::t_job r_job;
    logic           r_valid;
    logic [1:0]     r_idx;
    logic           free;

    assign o_last   = (r_idx == (r_job.count - 2'd1));
    assign free     = !r_valid || (i_ready && o_last);
    assign o_pop    = free && !i_empty;
    assign o_valid  = r_valid;
    assign o_kind   = r_job.kind;
    assign o_status = r_job.status;

    always_comb begin
        case (r_idx)
            2'd1:    o_byte = r_job.bytes[1];
            2'd2:    o_byte = r_job.bytes[2];
            default: o_byte = r_job.bytes[0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_job <= i_job;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (free) begin
            r_valid <= !i_empty;
            r_idx   <= '0;
        end else if (i_ready) begin
            r_idx   <= r_idx + 2'd1;
        end
    end

endmodule

>>> rtl/core/base64_stream_decoder_unit.sv
// top level of the streaming base64 decoder
// depends on b64d_pkg, b64d_front, b64d_queue, b64d_back

// Streaming base64 decoder, standard alphabet with '=' padding. One character
// request is taken per clock while the job queue has room; tuser selects a data
// character (0) or a finish (1), tlast marks the last character of a chunk. A
// character that closes a quartet gives one to three byte results (fewer where
// padding stands, a padded quartet must close its chunk and ends the stream);
// errors, finish requests and everything after an error give one status report,
// and errors stay until reset. The front part updates quartet state in the cycle
// a request is taken and queues a job, the back part sends one result per clock
// from an output register, so the input side takes one character per cycle as
// long as the result side keeps up: a full quartet of four characters gives
// three results. The input stalls only when the job queue (QUEUE_DEPTH jobs)
// fills up: under result backpressure, or, with the default depth, when report
// requests follow right behind a quartet that gives two or three bytes. A job
// passes through the job queue and then the back part's output register.
module base64_stream_decoder_unit #(
    parameter int QUEUE_DEPTH = b64d_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // character requests
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] char_in
    input  logic        i_s_tlast,   // chunk_end
    input  logic        i_s_tuser,   // [0] operation
    // results
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // [7:0] byte_out, [8] status, [15:9] zero
    output logic        o_m_tlast,   // is_last
    output logic        o_m_tuser    // [0] kind
);

    logic           accept;
    logic           push;
    logic           pop;
    logic           q_full;
    logic           q_empty;
    b64d_pkg::t_job f_job;
    b64d_pkg::t_job q_job;
    logic [7:0]     res_byte;
    logic           res_status;

    // a request is taken whenever the queue has room for its job
    assign o_s_tready = !q_full;
    assign accept     = i_s_tvalid && o_s_tready;

    b64d_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_op        (i_s_tuser),
        .i_char      (i_s_tdata),
        .i_chunk_end (i_s_tlast),
        .o_push      (push),
        .o_job       (f_job)
    );

    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (f_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_job   (q_job)
    );

    b64d_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (q_empty),
        .i_job    (q_job),
        .o_pop    (pop),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_kind   (o_m_tuser),
        .o_byte   (res_byte),
        .o_status (res_status),
        .o_last   (o_m_tlast)
    );

    // pack result fields, lowest first
    assign o_m_tdata = {7'd0, res_status, res_byte};

endmodule

>>> rtl/core/b64d_checker.sv
// port-level checks for the base64 stream decoder, bound to the top level
// depends on b64d_pkg and base64_stream_decoder_unit
module b64d_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata,
    input logic        o_m_tlast,
    input logic        o_m_tuser
);

    logic r_seen_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_err <= 1'b0;
        end else if (o_m_tvalid && i_m_tready && o_m_tuser == b64d_pkg::KIND_STATUS
                     && o_m_tdata[8] == b64d_pkg::ST_ERR) begin
            r_seen_err <= 1'b1;
        end
    end

    // no result shows right after a reset cycle
    a_reset_idle: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // a stalled result keeps its payload
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=>
            o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast) && $stable(o_m_tuser))
        else $error("stalled result changed");

    // a status report is a lone result with no byte; a data byte carries ok status
    a_report_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser == b64d_pkg::KIND_STATUS)
            ? (o_m_tlast && o_m_tdata[7:0] == 8'd0)
            : (o_m_tdata[8] == b64d_pkg::ST_OK))
        else $error("malformed result");

    // after an error report every result is an error report
    a_sticky_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && r_seen_err |->
            o_m_tuser == b64d_pkg::KIND_STATUS && o_m_tdata[8] == b64d_pkg::ST_ERR)
        else $error("result after error is not an error report");

endmodule

bind base64_stream_decoder_unit b64d_checker u_b64d_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast),
    .o_m_tuser  (o_m_tuser)
);
